// ===== rtl/core/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg: shared definitions for the permutation slot picker
// Field widths, result status codes, datapath operation codes and the
// command and status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psp_pkg;

  localparam int DRAW_W        = 10;
  localparam int SLOT_W        = 10;
  localparam int STATUS_W      = 2;
  localparam int OFF_W         = 11;
  localparam int COUNT_W       = 11;
  localparam int SLOTS_DEFAULT = 1024;
  localparam int LAST_RESET    = 1023;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DRAW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd2;

  // Datapath operations.
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_WALK  = 3'd3;
  localparam logic [2:0] OP_MARK  = 3'd4;
  localparam logic [2:0] OP_COMP  = 3'd5;

  typedef struct packed {
    logic                latch;
    logic                zero_count;
    logic [2:0]          op;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } psp_cmd_t;

  typedef struct packed {
    logic bad_draw;
    logic complete;
    logic free;
    logic step_lim;
    logic at_k;
    logic clr_done;
  } psp_stat_t;

endpackage

// ===== rtl/core/psp_if.sv =====
// ----------------------------------------------------------------------------
// psp_if: channel interfaces of the permutation slot picker
// Draw channel, result channel and configuration write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psp_item_if import psp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] draw;
  logic              first;

  modport source (output valid, output draw, output first, input ready);
  modport sink   (input valid, input draw, input first, output ready);
endinterface

interface psp_result_if import psp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic                last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot, output last, output status, input ready);
  modport sink   (input valid, input slot, input last, input status, output ready);
endinterface

interface psp_cfg_if import psp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/psp_ram.sv =====
// ----------------------------------------------------------------------------
// psp_ram: generic simple dual-port RAM
// One write port and one read port, registered read data (old data on a
// read of the address being written).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psp_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/psp_ctrl.sv =====
// ----------------------------------------------------------------------------
// psp_ctrl: controller of the permutation slot picker
// Sequences the clearing pass, the range checks, the walk to a free slot,
// the path compression and the hand-over of the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psp_ctrl import psp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_first,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  psp_stat_t stat,
  output psp_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_COMP  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state, state_next;
  logic                pending, pending_next;
  logic [STATUS_W-1:0] res_code, res_code_next;
  logic                out_valid_next;

  always_comb begin
    state_next     = state;
    pending_next   = pending;
    res_code_next  = res_code;
    in_ready       = 1'b0;
    cmd.latch      = 1'b0;
    cmd.zero_count = 1'b0;
    cmd.op         = OP_HOLD;
    cmd.load_out   = 1'b0;
    cmd.status     = res_code;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) begin
          state_next   = pending ? S_CHECK : S_IDLE;
          pending_next = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (in_first) begin
            cmd.zero_count = 1'b1;
            pending_next   = 1'b1;
            state_next     = S_CLEAR;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        priority if (stat.bad_draw) begin
          res_code_next = ST_BAD_DRAW;
          state_next    = S_RESP;
        end else if (stat.complete) begin
          res_code_next = ST_COMPLETE;
          state_next    = S_RESP;
        end else begin
          cmd.op     = OP_START;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        priority if (stat.free) begin
          cmd.op     = OP_MARK;
          state_next = S_COMP;
        end else if (stat.step_lim) begin
          // The chain closes on itself without a free slot.
          res_code_next = ST_COMPLETE;
          state_next    = S_RESP;
        end else begin
          cmd.op = OP_WALK;
        end
      end
      S_COMP: begin
        if (stat.at_k || stat.step_lim) begin
          res_code_next = ST_OK;
          state_next    = S_RESP;
        end else begin
          cmd.op = OP_COMP;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pending   <= 1'b0;
      res_code  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      res_code  <= res_code_next;
      out_valid <= out_valid_next;
    end
  end

  a_reset_clears : assert property (@(posedge clk) $fell(rst) |-> state == S_CLEAR)
    else $error("psp_ctrl: clearing pass does not start after reset");

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("psp_ctrl: result register overwritten before it was taken");

endmodule

// ===== rtl/core/psp_dp.sv =====
// ----------------------------------------------------------------------------
// psp_dp: datapath of the permutation slot picker
// Holds the skip offset memory, the walk position, the step counter, the
// draw count, the configuration register and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psp_dp import psp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  psp_cmd_t            cmd,
  output psp_stat_t           stat,
  input  logic [DRAW_W-1:0]   in_draw,
  input  logic                cfg_valid,
  input  logic [SLOT_W-1:0]   cfg_data,
  output logic [SLOT_W-1:0]   slot,
  output logic                last,
  output logic [STATUS_W-1:0] status
);

  // Slots beyond the reach of a draw are never addressed.
  localparam int MEM_DEPTH  = (SLOTS < (1 << DRAW_W)) ? SLOTS : (1 << DRAW_W);
  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int SW         = $clog2(SLOTS + 1);
  localparam int LAST_MAX_I = (SLOTS - 1 < LAST_RESET) ? SLOTS - 1 : LAST_RESET;
  localparam logic [SLOT_W-1:0]  LAST_MAX  = SLOT_W'(LAST_MAX_I);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1 << DRAW_W);

  logic [SLOT_W-1:0]   last_index;
  logic [COUNT_W-1:0]  draws_done;
  logic [DRAW_W-1:0]   draw_q;
  logic [SLOT_W-1:0]   pos, pos_next;
  logic [SLOT_W-1:0]   k_q;
  logic [SLOT_W-1:0]   na_q;
  logic [SW-1:0]       steps;
  logic [AW-1:0]       clr_addr;
  logic [SLOT_W-1:0]   slot_q;
  logic                last_q;
  logic [STATUS_W-1:0] status_q;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [OFF_W-1:0]    wdata;
  logic [OFF_W-1:0]    rdata;
  logic [SLOT_W+1:0]   target;
  logic [SLOT_W-1:0]   adv;
  logic                at_last;
  logic [OFF_W-1:0]    mark_val;
  logic [OFF_W-1:0]    comp_val;

  // One step along the stored offset; a target outside 0..last_index wraps to 0.
  always_comb begin
    target = {2'b00, pos} + {rdata[OFF_W-1], rdata};
    if (target[SLOT_W+1] || (target[SLOT_W:0] > {1'b0, last_index})) begin
      adv = '0;
    end else begin
      adv = target[SLOT_W-1:0];
    end
  end

  assign at_last  = (pos == last_index);
  assign mark_val = at_last ? (OFF_W'(0) - {1'b0, pos}) : OFF_W'(1);
  assign comp_val = {1'b0, na_q} - {1'b0, pos};

  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = comp_val;
    unique case (cmd.op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      OP_MARK: begin
        we    = 1'b1;
        wdata = mark_val;
      end
      OP_COMP: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_START, OP_MARK: pos_next = draw_q;
      OP_WALK, OP_COMP:  pos_next = adv;
      default:           pos_next = pos;
    endcase
  end

  psp_ram #(
    .WIDTH(OFF_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(pos_next[AW-1:0]),
    .rdata(rdata)
  );

  assign stat.bad_draw = (draw_q > last_index);
  assign stat.complete = (draws_done > {1'b0, last_index});
  assign stat.free     = (rdata == '0);
  assign stat.step_lim = (steps >= SW'(SLOTS));
  assign stat.at_k     = (pos == k_q);
  assign stat.clr_done = (clr_addr == AW'(MEM_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= LAST_MAX;
      draws_done <= '0;
      clr_addr   <= '0;
    end else begin
      if (cfg_valid) begin
        last_index <= (cfg_data > LAST_MAX) ? LAST_MAX : cfg_data;
      end
      if (cmd.zero_count) begin
        draws_done <= '0;
      end else if (cmd.load_out && (cmd.status == ST_OK)) begin
        draws_done <= draws_done + 1'b1;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= stat.clr_done ? '0 : clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      draw_q <= in_draw;
    end
    pos <= pos_next;
    unique case (cmd.op)
      OP_START: steps <= '0;
      OP_MARK: begin
        steps <= '0;
        k_q   <= pos;
        na_q  <= at_last ? '0 : pos + 1'b1;
      end
      OP_WALK, OP_COMP: steps <= steps + 1'b1;
      default: steps <= steps;
    endcase
    if (cmd.load_out) begin
      if (cmd.status == ST_OK) begin
        slot_q <= k_q;
        last_q <= (draws_done == {1'b0, last_index});
      end else begin
        slot_q <= '0;
        last_q <= 1'b0;
      end
      status_q <= cmd.status;
    end
  end

  assign slot   = slot_q;
  assign last   = last_q;
  assign status = status_q;

  a_comp_skips_k : assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COMP) |-> (pos != k_q))
    else $error("psp_dp: compression rewrites the chosen slot");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    draws_done <= COUNT_MAX)
    else $error("psp_dp: draw count beyond the table size");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && (cmd.status == ST_OK)) |=> (draws_done == $past(draws_done) + 1'b1))
    else $error("psp_dp: draw count not advanced on a good draw");

endmodule

// ===== rtl/core/permutation_slot_picker.sv =====
// ----------------------------------------------------------------------------
// permutation_slot_picker: random permutation builder, one slot per draw
// Walks stored skip offsets from a random draw to the next free slot, marks
// it taken and compresses the visited path.
// ----------------------------------------------------------------------------
// Usage. A transaction on the item channel brings a draw and a first flag;
// each draw gives exactly one transaction on the result channel, in order.
// The cfg channel writes last_index and is always ready; write it only while
// no draw is in flight.
// Flow. A draw passes the range checks, then the walk to the free slot and
// the compression pass, each one offset memory access per cycle. Draws
// that fail a range check go straight to the result. One draw is worked
// on at a time. A first flag starts a clearing pass over min(SLOTS, 1024)
// entries of the offset memory, one entry per cycle, before the draw is
// handled.
// Reset runs the same clearing pass; the item channel is not ready meanwhile.
// Stalls. The result waits in an output register; the next draw is accepted
// and worked on, and only its hand-over waits for the register to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_slot_picker import psp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  psp_item_if.sink     item,
  psp_result_if.source result,
  psp_cfg_if.sink      cfg
);

  psp_cmd_t  cmd;
  psp_stat_t stat;

  assign cfg.ready = 1'b1;

  psp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_first (item.first),
    .in_ready (item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psp_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_draw  (item.draw),
    .cfg_valid(cfg.valid),
    .cfg_data (cfg.data),
    .slot     (result.slot),
    .last     (result.last),
    .status   (result.status)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the permutation slot picker
// A directed table covers the corner cases, then random permutations of
// mostly small sizes follow, with random idling on both channels. Every
// result is checked against a fixed value from the table or a predictor with its own offset table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import psp_pkg::*; ();

  localparam int N_SLOTS      = SLOTS_DEFAULT;
  localparam int RANDOM_DRAWS = 450;
  localparam int CALM_AFTER   = 400;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 64;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                last;
    logic [STATUS_W-1:0] status;
  } pick_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_FIXED} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [SLOT_W-1:0] value;
    logic              first;
    pick_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  psp_item_if   item_ch ();
  psp_result_if result_ch ();
  psp_cfg_if    cfg_ch ();

  permutation_slot_picker DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: offset table, slots handed out and the highest slot.
  logic signed [OFF_W-1:0] skip_tab [N_SLOTS];
  int                      picks_made;
  logic [SLOT_W-1:0]       top_slot;

  pick_t pending [$];
  int    errors     = 0;
  int    n_checked  = 0;
  int    n_draws    = 0;
  int    n_directed = 0;
  int    n_settings = 0;
  int    status_seen [4] = '{default: 0};
  bit    calm       = 1'b0;
  bit    hold_req   = 1'b0;

  function automatic row_t mk_row(row_kind_e k, int v, bit f, int s, bit l,
                                  logic [STATUS_W-1:0] st);
    row_t r;
    r.kind        = k;
    r.value       = v[SLOT_W-1:0];
    r.first       = f;
    r.want.slot   = s[SLOT_W-1:0];
    r.want.last   = l;
    r.want.status = st;
    return r;
  endfunction

  // One step along the stored offsets; a target outside 0..top wraps to 0.
  function automatic logic [SLOT_W-1:0] hop(logic [SLOT_W-1:0] pos);
    int t;
    t = int'(pos) + int'(skip_tab[pos]);
    if (t < 0 || t > int'(top_slot)) return '0;
    return t[SLOT_W-1:0];
  endfunction

  function automatic pick_t pick_slot(logic [DRAW_W-1:0] d, logic f);
    pick_t             r;
    logic [SLOT_W-1:0] k;
    logic [SLOT_W-1:0] i;
    logic [SLOT_W-1:0] nx;
    int                steps;
    int                after;
    r = '0;
    if (f) begin
      foreach (skip_tab[j]) skip_tab[j] = '0;
      picks_made = 0;
    end
    if (d > top_slot) begin
      r.status = ST_BAD_DRAW;
      return r;
    end
    if (picks_made > int'(top_slot)) begin
      r.status = ST_COMPLETE;
      return r;
    end
    k     = d;
    steps = 0;
    while (skip_tab[k] != '0) begin
      if (steps >= N_SLOTS) begin
        r.status = ST_COMPLETE;
        return r;
      end
      k = hop(k);
      steps++;
    end
    if (k == top_slot) begin
      skip_tab[k] = OFF_W'(-int'(k));
      after       = 0;
    end else begin
      skip_tab[k] = OFF_W'(1);
      after       = int'(k) + 1;
    end
    // Path compression: every entry on the walk now points past the pick.
    i     = d;
    steps = 0;
    while (i != k && steps < N_SLOTS) begin
      nx          = hop(i);
      skip_tab[i] = OFF_W'(after - int'(i));
      i           = nx;
      steps++;
    end
    picks_made++;
    r.slot   = k;
    r.last   = (picks_made == int'(top_slot) + 1);
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_draw(logic [DRAW_W-1:0] d, logic f, bit use_fixed, pick_t fixed);
    pick_t pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.draw  <= d;
    item_ch.first <= f;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pred = pick_slot(d, f);
    pending.push_back(use_fixed ? fixed : pred);
    n_draws++;
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_top(logic [SLOT_W-1:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    top_slot = (int'(v) > N_SLOTS - 1) ? SLOT_W'(N_SLOTS - 1) : v;
    n_settings++;
  endtask

  // Result side: short random stalls, and one long hold-off on request.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    pick_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending.size() == 0) begin
        report_mismatch("result with nothing outstanding, slot", result_ch.slot, 0);
      end else begin
        want = pending.pop_front();
        n_checked++;
        status_seen[result_ch.status]++;
        if (result_ch.slot !== want.slot)
          report_mismatch("slot", result_ch.slot, want.slot);
        if (result_ch.last !== want.last)
          report_mismatch("last", result_ch.last, want.last);
        if (result_ch.status !== want.status)
          report_mismatch("status", result_ch.status, want.status);
      end
    end
  end

  initial begin
    row_t              plan [$];
    int                top;
    int                n;
    int                roll;
    int                phase;
    int                n_rand;
    logic [DRAW_W-1:0] d;
    logic              f;
    bit                fresh;

    item_ch.valid <= 1'b0;
    item_ch.draw  <= '0;
    item_ch.first <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    rst           <= 1'b1;
    foreach (skip_tab[j]) skip_tab[j] = '0;
    picks_made = 0;
    top_slot   = SLOT_W'(LAST_RESET);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset state first, including a wrap from the top slot back to zero.
    plan.push_back(mk_row(ROW_FIXED, 0, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_PRED, 0, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 1023, 0, 1023, 0, ST_OK));
    plan.push_back(mk_row(ROW_PRED, 1023, 0, 0, 0, ST_OK));
    // Shrinking the range below the count already drawn means complete;
    // a bad draw takes priority, and a first flag still clears.
    plan.push_back(mk_row(ROW_CFG, 3, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 2, 0, 0, 0, ST_COMPLETE));
    plan.push_back(mk_row(ROW_FIXED, 5, 0, 0, 0, ST_BAD_DRAW));
    plan.push_back(mk_row(ROW_FIXED, 7, 1, 0, 0, ST_BAD_DRAW));
    plan.push_back(mk_row(ROW_FIXED, 3, 0, 3, 0, ST_OK));
    plan.push_back(mk_row(ROW_PRED, 3, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_PRED, 2, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_PRED, 1, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 0, 0, 0, 0, ST_COMPLETE));
    // Widening the range leaves slots 1 to 3 in a closed loop of offsets,
    // so a walk into it never finds a free slot.
    plan.push_back(mk_row(ROW_CFG, 7, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 0, 0, 0, 0, ST_COMPLETE));
    plan.push_back(mk_row(ROW_FIXED, 6, 0, 6, 0, ST_OK));
    // A single slot is given once, then the count alone marks completion.
    plan.push_back(mk_row(ROW_CFG, 0, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 0, 1, 0, 1, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 0, 0, 0, 0, ST_COMPLETE));
    plan.push_back(mk_row(ROW_FIXED, 1023, 0, 0, 0, ST_BAD_DRAW));
    // A stale offset that now leads past the top slot wraps to zero.
    plan.push_back(mk_row(ROW_CFG, 1023, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 5, 1, 5, 0, ST_OK));
    plan.push_back(mk_row(ROW_CFG, 5, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_PRED, 5, 0, 0, 0, ST_OK));
    plan.push_back(mk_row(ROW_FIXED, 1023, 1, 0, 0, ST_BAD_DRAW));

    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_CFG: begin
          write_top(plan[r].value);
        end
        ROW_PRED: begin
          send_draw(plan[r].value, plan[r].first, 1'b0, '0);
          n_directed++;
        end
        default: begin
          send_draw(plan[r].value, plan[r].first, 1'b1, plan[r].want);
          n_directed++;
        end
      endcase
    end

    // Random permutations, mostly small so that many of them complete.
    phase  = 0;
    n_rand = 0;
    while (n_rand < RANDOM_DRAWS) begin
      roll = $urandom_range(0, 9);
      if (phase == 0 || roll == 2) top = 1023;
      else if (roll == 0) top = 0;
      else if (roll == 1) top = 1;
      else if (roll <= 6) top = $urandom_range(2, 15);
      else if (roll <= 8) top = $urandom_range(16, 63);
      else top = $urandom_range(64, 1022);
      write_top(SLOT_W'(top));
      // Now and then the old table is kept, so stale offsets get walked.
      fresh = (phase == 0) || ($urandom_range(0, 4) != 0);
      n = (top < 48) ? top + 1 + $urandom_range(0, 3) : $urandom_range(24, 48);
      for (int j = 0; j < n; j++) begin
        d    = DRAW_W'($urandom_range(0, top));
        f    = (j == 0) && fresh;
        roll = $urandom_range(0, 19);
        if (roll == 0) d = DRAW_W'($urandom_range(0, 1023));
        else if (roll == 1) f = 1'b1;
        if (n_rand == 150) hold_req = 1'b1;
        if (n_rand == 300) drain();
        calm = (n_rand >= CALM_AFTER);
        send_draw(d, f, 1'b0, '0);
        n_rand++;
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d draws (%0d from the table), %0d results checked, %0d settings",
             n_draws, n_directed, n_checked, n_settings);
    $display("summary: ok %0d, bad draw %0d, complete %0d, over %0d random permutations",
             status_seen[ST_OK], status_seen[ST_BAD_DRAW], status_seen[ST_COMPLETE], phase);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every draw clearing the table and
  // walking the full table, with the longest stalls on both sides.
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/psp_pkg.sv
rtl/core/psp_if.sv
rtl/core/psp_ram.sv
rtl/core/psp_ctrl.sv
rtl/core/psp_dp.sv
rtl/core/permutation_slot_picker.sv
tb/tb_top.sv
